>>> hw/rtl/runtime_hash_unit_core_assert.svh
// Assertion macros used by the checker file of the hash unit.
`ifndef RUNTIME_HASH_UNIT_CORE_ASSERT_SVH
`define RUNTIME_HASH_UNIT_CORE_ASSERT_SVH

// Same-cycle implication, disabled while reset is held.
`define RHU_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> cons) \
		else $error("hash unit assertion failed");

// Next-cycle implication, disabled while reset is held.
`define RHU_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> cons) \
		else $error("hash unit assertion failed");

`endif

>>> hw/rtl/rhu_pkg.sv
// Types and constants of the runtime hash unit.
package rhu_pkg;

	localparam logic [63:0] FNV_BASIS = 64'hcbf29ce484222325;
	localparam logic [63:0] FNV_PRIME = 64'h00000100000001b3;
	localparam logic [63:0] MIX_MUL_A = 64'hff51afd7ed558ccd;
	localparam logic [63:0] MIX_MUL_B = 64'hc4ceb9fe1a85ec53;
	localparam logic [63:0] GOLDEN    = 64'h9e3779b97f4a7c15;
	localparam int          MIX_SHIFT = 33;

	localparam logic [2:0] KIND_BYTE    = 3'd0;
	localparam logic [2:0] KIND_UNIT16  = 3'd1;
	localparam logic [2:0] KIND_INT     = 3'd2;
	localparam logic [2:0] KIND_BOOL    = 3'd3;
	localparam logic [2:0] KIND_COMBINE = 3'd4;
	localparam logic [2:0] KIND_EMPTY   = 3'd5;

	typedef struct packed {
		logic        start;
		logic [63:0] a;
		logic [63:0] b;
	} mul_req_t;

	typedef struct packed {
		logic        done;
		logic [63:0] product;
	} mul_rsp_t;

endpackage

>>> hw/rtl/runtime_hash_unit_core.sv
// Top level of the runtime hash unit: sequencer, running string hash and output register.
// Each accepted transaction is worked on alone while in_ready is low. Every 64-bit multiply
// goes through one shared iterative multiplier built on a single 32 x 32 multiplier, and
// three partial products are used. A byte unit that does not end a string lets the next
// transaction in once its one multiply is done. A 16-bit unit that does not end a string
// lets it in only after its second multiply, because its two multiplies depend on each
// other. A byte or 16-bit unit that ends a string and each mix kind put their result in
// res_q when their last multiply is done; a combine goes through S_CMB1 and S_CMB2 first,
// and an empty string goes straight to S_OUT. From S_OUT the result is moved into the
// output register, out_valid is raised and the sequencer returns to S_IDLE in the same
// cycle, after which the next transaction can be accepted by the sequencer. This holds when
// the output register is free. If a finished result finds the output register still
// occupied, the sequencer holds it and in_ready stays low until out_ready drains the
// register. The next transaction is accepted while a finished result still waits in the
// output register. Kinds 6 and 7 are dropped at acceptance with no result, so the next
// transaction can follow in the next cycle.
module runtime_hash_unit_core
	import rhu_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [2:0]  kind,
	input  logic [63:0] data,
	input  logic [63:0] second_operand,
	input  logic        last,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [63:0] hash_value
);

	typedef enum logic [2:0] {
		S_IDLE,
		S_F1_WAIT,
		S_F2_WAIT,
		S_M1_WAIT,
		S_M2_WAIT,
		S_CMB1,
		S_CMB2,
		S_OUT
	} state_t;

	state_t      state_q;
	logic [63:0] hash_q;
	logic [63:0] data_q;
	logic [63:0] acc_q;
	logic [63:0] res_q;
	logic [63:0] mul_a_q;
	logic [63:0] mul_b_q;
	logic        mul_start_q;
	logic        is16_q;
	logic        last_q;
	logic        out_valid_q;
	logic [63:0] hash_value_q;

	mul_req_t    mreq;
	mul_rsp_t    mrsp;
	logic        accept;
	logic        slot_free;
	logic        mul_go;
	logic [63:0] mix_in;
	logic [63:0] mix_pre;
	logic [63:0] mix_mid;

	assign mreq.start = mul_start_q;
	assign mreq.a     = mul_a_q;
	assign mreq.b     = mul_b_q;

	rhu_mul u_mul (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (mreq),
		.rsp    (mrsp)
	);

	assign in_ready  = (state_q == S_IDLE);
	assign accept    = in_valid && in_ready;
	assign slot_free = !out_valid_q || out_ready;

	always_comb begin
		mix_in  = (kind == KIND_BOOL) ? {63'd0, |data} : data;
		mix_pre = mix_in ^ (mix_in >> MIX_SHIFT);
		mix_mid = mrsp.product ^ (mrsp.product >> MIX_SHIFT);
	end

	// The multiplier is launched for a string unit or a mix kind, for the high byte of a
	// 16-bit unit, and for the second multiply of a mix.
	always_comb begin
		case (state_q)
			S_IDLE:    mul_go = accept && (kind == KIND_BYTE || kind == KIND_UNIT16 ||
				kind == KIND_INT || kind == KIND_BOOL);
			S_F1_WAIT: mul_go = mrsp.done && is16_q;
			S_M1_WAIT: mul_go = mrsp.done;
			default:   mul_go = 1'b0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			hash_q       <= FNV_BASIS;
			data_q       <= '0;
			acc_q        <= '0;
			res_q        <= '0;
			mul_a_q      <= '0;
			mul_b_q      <= '0;
			mul_start_q  <= 1'b0;
			is16_q       <= 1'b0;
			last_q       <= 1'b0;
			out_valid_q  <= 1'b0;
			hash_value_q <= '0;
		end else begin
			mul_start_q <= mul_go;
			// In S_OUT the output register is refilled in the same cycle that it drains.
			if (out_valid_q && out_ready && state_q != S_OUT) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						data_q <= data;
						is16_q <= (kind == KIND_UNIT16);
						last_q <= last;
						case (kind)
							KIND_BYTE, KIND_UNIT16: begin
								mul_a_q <= hash_q ^ {56'd0, data[7:0]};
								mul_b_q <= FNV_PRIME;
								state_q <= S_F1_WAIT;
							end
							KIND_INT, KIND_BOOL: begin
								mul_a_q <= mix_pre;
								mul_b_q <= MIX_MUL_A;
								state_q <= S_M1_WAIT;
							end
							KIND_COMBINE: begin
								acc_q   <= second_operand + GOLDEN;
								state_q <= S_CMB1;
							end
							KIND_EMPTY: begin
								res_q   <= FNV_BASIS;
								state_q <= S_OUT;
							end
							default: begin
								state_q <= S_IDLE;
							end
						endcase
					end
				end
				S_F1_WAIT, S_F2_WAIT: begin
					if (mrsp.done) begin
						if (state_q == S_F1_WAIT && is16_q) begin
							// The high byte of a 16-bit unit goes in as a second FNV round.
							mul_a_q <= mrsp.product ^ {56'd0, data_q[15:8]};
							mul_b_q <= FNV_PRIME;
							state_q <= S_F2_WAIT;
						end else if (last_q) begin
							res_q   <= mrsp.product;
							hash_q  <= FNV_BASIS;
							state_q <= S_OUT;
						end else begin
							hash_q  <= mrsp.product;
							state_q <= S_IDLE;
						end
					end
				end
				S_M1_WAIT: begin
					if (mrsp.done) begin
						mul_a_q <= mix_mid;
						mul_b_q <= MIX_MUL_B;
						state_q <= S_M2_WAIT;
					end
				end
				S_M2_WAIT: begin
					if (mrsp.done) begin
						res_q   <= mix_mid;
						state_q <= S_OUT;
					end
				end
				S_CMB1: begin
					acc_q   <= acc_q + (data_q << 6);
					state_q <= S_CMB2;
				end
				S_CMB2: begin
					res_q   <= data_q ^ (acc_q + (data_q >> 2));
					state_q <= S_OUT;
				end
				S_OUT: begin
					if (slot_free) begin
						hash_value_q <= res_q;
						out_valid_q  <= 1'b1;
						state_q      <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign out_valid  = out_valid_q;
	assign hash_value = hash_value_q;

endmodule

>>> hw/rtl/rhu_mul.sv
// Iterative 64 x 64 multiplier giving the low 64 bits from one 32 x 32 multiplier.
module rhu_mul
	import rhu_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  mul_req_t req,
	output mul_rsp_t rsp
);

	logic [63:0] a_q;
	logic [63:0] b_q;
	logic [63:0] prod_q;
	logic [63:0] acc_q;
	logic [1:0]  phase_q;
	logic        busy_q;
	logic        done_q;
	logic [31:0] op_x;
	logic [31:0] op_y;

	// Low by low first, then the two cross products, whose low halves land in the upper word.
	always_comb begin
		case (phase_q)
			2'd0: begin
				op_x = a_q[31:0];
				op_y = b_q[31:0];
			end
			2'd1: begin
				op_x = a_q[31:0];
				op_y = b_q[63:32];
			end
			2'd2: begin
				op_x = a_q[63:32];
				op_y = b_q[31:0];
			end
			default: begin
				op_x = a_q[63:32];
				op_y = b_q[63:32];
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			a_q     <= '0;
			b_q     <= '0;
			prod_q  <= '0;
			acc_q   <= '0;
			phase_q <= '0;
			busy_q  <= 1'b0;
			done_q  <= 1'b0;
		end else if (req.start) begin
			a_q     <= req.a;
			b_q     <= req.b;
			phase_q <= '0;
			busy_q  <= 1'b1;
			done_q  <= 1'b0;
		end else if (busy_q) begin
			prod_q  <= op_x * op_y;
			phase_q <= phase_q + 2'd1;
			case (phase_q)
				2'd1:    acc_q <= prod_q;
				2'd2:    acc_q[63:32] <= acc_q[63:32] + prod_q[31:0];
				2'd3:    acc_q[63:32] <= acc_q[63:32] + prod_q[31:0];
				default: acc_q <= acc_q;
			endcase
			if (phase_q == 2'd3) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end else begin
			done_q <= 1'b0;
		end
	end

	assign rsp.done    = done_q;
	assign rsp.product = acc_q;

endmodule

>>> hw/rtl/rhu_checker.sv
// Port-level checker for the runtime hash unit and its bind to the top level.
`include "runtime_hash_unit_core_assert.svh"

module rhu_checker
	import rhu_pkg::*;
(
	input logic        clk,
	input logic        arst_n,
	input logic        in_valid,
	input logic        in_ready,
	input logic [2:0]  kind,
	input logic        out_valid,
	input logic        out_ready,
	input logic [63:0] hash_value
);

	`RHU_ASSERT_NEXT(a_out_valid_holds, clk, arst_n, out_valid && !out_ready, out_valid)

	`RHU_ASSERT_NEXT(a_out_data_holds, clk, arst_n, out_valid && !out_ready, $stable(hash_value))

	// Any defined kind keeps the unit busy for at least the cycle after its transaction.
	`RHU_ASSERT_NEXT(a_busy_after_accept, clk, arst_n, in_valid && in_ready && kind <= KIND_EMPTY, !in_ready)

	// An empty string answers with the offset basis when the output is free.
	`RHU_ASSERT_IMPL(a_empty_answer, clk, arst_n, in_valid && in_ready && kind == KIND_EMPTY && !out_valid, ##2 (out_valid && hash_value == FNV_BASIS))

endmodule

bind runtime_hash_unit_core rhu_checker u_rhu_checker (.*);

>>> dv/runtime_hash_unit_core_tb.sv
// Self-checking testbench for the runtime hash unit core with random handshake idling.
`timescale 1ns / 1ps

module runtime_hash_unit_core_tb;
	import rhu_pkg::*;

	// Kinds that the unit drops without a result.
	localparam logic [2:0] KIND_SPARE_6 = 3'd6;
	localparam logic [2:0] KIND_SPARE_7 = 3'd7;

	localparam int RANDOM_UNITS   = 700;
	localparam int HOLD_OFF_AT    = 200;
	localparam int HOLD_OFF_LEN   = 400;
	localparam int DRAIN_CYCLES   = 30;
	localparam int WATCHDOG_LIMIT = 5000;

	typedef struct {
		logic [2:0]  kind;
		logic [63:0] data;
		logic [63:0] operand;
		logic        last;
	} hash_req_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_ready;
	logic [2:0]  kind = KIND_BYTE;
	logic [63:0] data = '0;
	logic [63:0] second_operand = '0;
	logic        last = 1'b0;
	logic        out_valid;
	logic        out_ready = 1'b0;
	logic [63:0] hash_value;

	hash_req_t   pending_reqs[$];
	logic [63:0] expected_hashes[$];
	logic [63:0] string_hash;
	int          mismatch_cnt = 0;
	int          accepted_cnt = 0;
	int          unit_cnt = 0;

	runtime_hash_unit_core u_dut (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (in_valid),
		.in_ready       (in_ready),
		.kind           (kind),
		.data           (data),
		.second_operand (second_operand),
		.last           (last),
		.out_valid      (out_valid),
		.out_ready      (out_ready),
		.hash_value     (hash_value)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	function automatic logic [63:0] fnv_fold_byte(logic [63:0] h, logic [7:0] b);
		return (h ^ {56'd0, b}) * FNV_PRIME;
	endfunction

	function automatic logic [63:0] murmur_finalize(logic [63:0] v);
		v = v ^ (v >> MIX_SHIFT);
		v = v * MIX_MUL_A;
		v = v ^ (v >> MIX_SHIFT);
		v = v * MIX_MUL_B;
		return v ^ (v >> MIX_SHIFT);
	endfunction

	function automatic logic [63:0] seed_combine(logic [63:0] seed, logic [63:0] value);
		return seed ^ (value + GOLDEN + (seed << 6) + (seed >> 2));
	endfunction

	// Returns 1 when the transaction produces a hash; updates the running string hash.
	function automatic bit predict_hash(hash_req_t req, output logic [63:0] result);
		result = '0;
		case (req.kind)
			KIND_BYTE, KIND_UNIT16: begin
				string_hash = fnv_fold_byte(string_hash, req.data[7:0]);
				if (req.kind == KIND_UNIT16)
					string_hash = fnv_fold_byte(string_hash, req.data[15:8]);
				if (!req.last)
					return 1'b0;
				result = string_hash;
				string_hash = FNV_BASIS;
				return 1'b1;
			end
			KIND_INT: begin
				result = murmur_finalize(req.data);
				return 1'b1;
			end
			KIND_BOOL: begin
				result = murmur_finalize({63'd0, req.data != '0});
				return 1'b1;
			end
			KIND_COMBINE: begin
				result = seed_combine(req.data, req.operand);
				return 1'b1;
			end
			KIND_EMPTY: begin
				result = FNV_BASIS;
				return 1'b1;
			end
			default: return 1'b0;
		endcase
	endfunction

	function automatic int idle_len();
		int r;
		r = $urandom_range(0, 99);
		if (r < 50)
			return 0;
		if (r < 85)
			return $urandom_range(1, 3);
		if (r < 97)
			return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	function automatic logic [63:0] rand64();
		return {$urandom, $urandom};
	endfunction

	function automatic logic [63:0] edgy64();
		int r;
		r = $urandom_range(0, 9);
		if (r == 0)
			return '0;
		if (r == 1)
			return '1;
		if (r == 2)
			return 64'd1 << $urandom_range(0, 63);
		return rand64();
	endfunction

	task automatic push_req(logic [2:0] k, logic [63:0] d, logic [63:0] op, logic l);
		hash_req_t req;
		req = '{kind: k, data: d, operand: op, last: l};
		pending_reqs.push_back(req);
		if (k != KIND_SPARE_6 && k != KIND_SPARE_7)
			unit_cnt++;
	endtask

	task automatic queue_oneshot();
		logic [63:0] d;
		case ($urandom_range(0, 3))
			0: push_req(KIND_INT, edgy64(), rand64(), 1'($urandom_range(0, 1)));
			1: begin
				case ($urandom_range(0, 4))
					0, 1: d = '0;
					2: d = 64'd1;
					3: d = 64'd1 << $urandom_range(0, 63);
					default: d = rand64();
				endcase
				push_req(KIND_BOOL, d, rand64(), 1'($urandom_range(0, 1)));
			end
			2: push_req(KIND_COMBINE, edgy64(), edgy64(), 1'($urandom_range(0, 1)));
			default: push_req(KIND_EMPTY, rand64(), rand64(), 1'($urandom_range(0, 1)));
		endcase
	endtask

	task automatic queue_spare();
		push_req($urandom_range(0, 1) ? KIND_SPARE_7 : KIND_SPARE_6, rand64(), rand64(),
			1'($urandom_range(0, 1)));
	endtask

	// A string of code units with random content, now and then interrupted by other kinds.
	task automatic queue_string();
		int len;
		int r;
		len = ($urandom_range(0, 9) == 0) ? $urandom_range(7, 20) : $urandom_range(1, 6);
		for (int i = 0; i < len; i++) begin
			r = $urandom_range(0, 99);
			if (r < 8)
				queue_oneshot();
			else if (r < 11)
				queue_spare();
			push_req($urandom_range(0, 1) ? KIND_UNIT16 : KIND_BYTE, rand64(), rand64(),
				i == len - 1);
		end
	endtask

	// Sender: accepts, predicts and offers the next pending transaction after a random gap.
	hash_req_t   acc_req;
	hash_req_t   next_req;
	logic [63:0] acc_hash;
	int          send_gap;
	int          send_calm;

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
			kind <= KIND_BYTE;
			data <= '0;
			second_operand <= '0;
			last <= 1'b0;
			accepted_cnt <= 0;
			string_hash = FNV_BASIS;
			send_gap = 0;
			send_calm = 0;
		end else begin
			if (in_valid && in_ready) begin
				acc_req = '{kind: kind, data: data, operand: second_operand, last: last};
				if (predict_hash(acc_req, acc_hash))
					expected_hashes.push_back(acc_hash);
				accepted_cnt <= accepted_cnt + 1;
			end
			if (!in_valid || in_ready) begin
				if (send_gap > 0) begin
					send_gap--;
					in_valid <= 1'b0;
				end else if (pending_reqs.size() > 0) begin
					next_req = pending_reqs.pop_front();
					kind <= next_req.kind;
					data <= next_req.data;
					second_operand <= next_req.operand;
					last <= next_req.last;
					in_valid <= 1'b1;
					if (send_calm > 0) begin
						send_calm--;
						send_gap = 0;
					end else begin
						send_gap = idle_len();
						if ($urandom_range(0, 49) == 0)
							send_calm = $urandom_range(20, 60);
					end
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// Receiver: checks each result transaction and stalls at random.
	logic [63:0] want_hash;
	int          stall_left;
	int          recv_calm;
	int          hold_left;
	bit          hold_done;

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_ready <= 1'b0;
			stall_left = 0;
			recv_calm = 0;
			hold_left = 0;
			hold_done = 1'b0;
		end else begin
			if (out_valid && out_ready) begin
				if (expected_hashes.size() == 0) begin
					$error("hash_value: no result expected, actual %h", hash_value);
					mismatch_cnt++;
				end else begin
					want_hash = expected_hashes.pop_front();
					if (hash_value !== want_hash) begin
						$error("hash_value: expected %h, actual %h", want_hash, hash_value);
						mismatch_cnt++;
					end
				end
			end
			// One long hold-off lets the output register and the core back up into the input.
			if (!hold_done && accepted_cnt >= HOLD_OFF_AT) begin
				hold_done = 1'b1;
				hold_left = HOLD_OFF_LEN;
			end
			if (hold_left > 0) begin
				hold_left--;
				out_ready <= 1'b0;
			end else if (stall_left > 0) begin
				stall_left--;
				out_ready <= 1'b0;
			end else begin
				out_ready <= 1'b1;
				if (recv_calm > 0) begin
					recv_calm--;
				end else if ($urandom_range(0, 3) == 0) begin
					stall_left = idle_len();
				end else if ($urandom_range(0, 39) == 0) begin
					recv_calm = $urandom_range(30, 100);
				end
			end
		end
	end

	int idle_cycles = 0;

	always @(posedge clk) begin
		if (arst_n) begin
			if ((in_valid && in_ready) || (out_valid && out_ready))
				idle_cycles <= 0;
			else
				idle_cycles <= idle_cycles + 1;
			if (idle_cycles >= WATCHDOG_LIMIT) begin
				$display("Mismatches found");
				$finish;
			end
		end
	end

	initial begin
		// Directed: zero and full code units, units cut by other kinds, every kind at its edges.
		push_req(KIND_BYTE, 64'd0, 64'd0, 1'b1);
		push_req(KIND_BYTE, '1, '1, 1'b0);
		push_req(KIND_UNIT16, '1, 64'd0, 1'b0);
		push_req(KIND_EMPTY, 64'd0, '1, 1'b0);
		push_req(KIND_INT, 64'd0, '1, 1'b1);
		push_req(KIND_SPARE_6, '1, '1, 1'b1);
		push_req(KIND_BYTE, 64'hffff_ffff_ffff_ff41, 64'd0, 1'b1);
		push_req(KIND_UNIT16, 64'd0, 64'd0, 1'b1);
		push_req(KIND_UNIT16, 64'hdead_beef_0000_ffff, 64'd0, 1'b1);
		push_req(KIND_UNIT16, 64'h0123_4567_89ab_cdef, 64'd0, 1'b0);
		push_req(KIND_SPARE_7, 64'd0, 64'd0, 1'b0);
		push_req(KIND_BYTE, 64'd0, 64'd0, 1'b1);
		push_req(KIND_INT, '1, 64'd0, 1'b0);
		push_req(KIND_INT, 64'd1, 64'd0, 1'b0);
		push_req(KIND_INT, 64'h8000_0000_0000_0000, 64'd0, 1'b0);
		push_req(KIND_BOOL, 64'd0, '1, 1'b0);
		push_req(KIND_BOOL, 64'd1, 64'd0, 1'b1);
		push_req(KIND_BOOL, '1, 64'd0, 1'b0);
		push_req(KIND_BOOL, 64'h8000_0000_0000_0000, 64'd0, 1'b0);
		push_req(KIND_COMBINE, 64'd0, 64'd0, 1'b0);
		push_req(KIND_COMBINE, '1, '1, 1'b1);
		push_req(KIND_COMBINE, 64'h0123_4567_89ab_cdef, 64'hfedc_ba98_7654_3210, 1'b0);
		push_req(KIND_EMPTY, '1, 64'd0, 1'b1);
		unit_cnt = 0;
		while (unit_cnt < RANDOM_UNITS) begin
			case ($urandom_range(0, 19))
				0: queue_spare();
				1, 2, 3, 4, 5: queue_oneshot();
				default: queue_string();
			endcase
		end

		repeat (10) @(posedge clk);
		@(negedge clk) arst_n = 1'b1;
		do
			@(negedge clk);
		while (pending_reqs.size() != 0 || in_valid);
		while (expected_hashes.size() != 0)
			@(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);
		if (mismatch_cnt == 0 && expected_hashes.size() == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

endmodule

>>> sim.f
+incdir+hw/rtl
hw/rtl/rhu_pkg.sv
hw/rtl/rhu_mul.sv
hw/rtl/runtime_hash_unit_core.sv
hw/rtl/rhu_checker.sv
dv/runtime_hash_unit_core_tb.sv
